[hdl/cpt_pkg.sv]
package cpt_pkg;

   // width of the classification code on the result port
   localparam int CODE_WIDTH = 2;

   // classification codes
   localparam logic [CODE_WIDTH-1:0] CLASS_NOT_PRIME  = 2'd0;
   localparam logic [CODE_WIDTH-1:0] CLASS_PRIME      = 2'd1;
   localparam logic [CODE_WIDTH-1:0] CLASS_CHEN_PRIME = 2'd2;
   localparam logic [CODE_WIDTH-1:0] CLASS_CHEN_SEMI  = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_EVAL,
      ST_VERDICT
   } state_type;

   // which test the sequencer is running
   typedef enum logic [1:0] {
      PH_CAND_PRIME,
      PH_PART_PRIME,
      PH_PART_SEMI,
      PH_COFACTOR_PRIME
   } phase_type;

   // control to the shared divider
   typedef struct packed {
      logic go;
   } div_ctl_type;

   // status back from the shared divider
   typedef struct packed {
      logic done;
      logic running;
   } div_stat_type;

endpackage

[hdl/cpt_div.sv]
module cpt_div #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpt_pkg::div_ctl_type ctl,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output cpt_pkg::div_stat_type stat,
   output logic [WIDTH-1:0]     quotient,
   output logic [WIDTH-1:0]     remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quot_ff, quot_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             running_ff, running_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   // one restoring step: shift in the next dividend bit, try to subtract
   assign trial = {rem_ff, quot_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      dsr_in     = dsr_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (ctl.go) begin
         rem_in     = '0;
         quot_in    = dividend;
         dsr_in     = divisor;
         cnt_in     = CW'(WIDTH);
         running_in = 1'b1;
      end else if (running_ff) begin
         if (!diff[WIDTH]) begin
            rem_in  = diff[WIDTH-1:0];
            quot_in = {quot_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = trial[WIDTH-1:0];
            quot_in = {quot_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   assign stat.done    = done_ff;
   assign stat.running = running_ff;
   assign quotient     = quot_ff;
   assign remainder    = rem_ff;

endmodule

[hdl/chen_prime_test.sv]
// response: negative inputs answer in the cycle after start; 0 and 1 settle in ST_CHECK and ST_VERDICT
// without division; otherwise one division per trial divisor (2, then odd divisors up to the square root),
// run on the bit-serial shared divider; worst case two full tests near 2^(WIDTH-1)
// throughput: one item at a time, a new item is taken while the last result is shown
// reset: synchronous, clears the sequencer, divider control and result strobe
// results come out as a one-cycle rsp_valid pulse; the receiver cannot stall
module chen_prime_test #(
   parameter int WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [WIDTH-1:0]          req_candidate,
   output logic                             rsp_valid,
   output logic [cpt_pkg::CODE_WIDTH-1:0]   rsp_class_code
);

   cpt_pkg::state_type state_ff, state_in;
   cpt_pkg::phase_type phase_ff, phase_in;

   // number under test and current trial divisor
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] d_ff, d_in;
   // outcome of the current test: prime for prime tests, semiprime for the semiprime test
   logic             verdict_ff, verdict_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cpt_pkg::CODE_WIDTH-1:0]  rsp_code_ff, rsp_code_in;

   cpt_pkg::div_ctl_type  div_ctl;
   cpt_pkg::div_stat_type div_stat;
   logic [WIDTH-1:0]      quotient;
   logic [WIDTH-1:0]      remainder;
   logic [WIDTH-1:0]      low_limit;

   // shared divider: gives n / d and n % d for every trial
   // the divisor is the next value so it arrives together with the go pulse
   cpt_div #(
      .WIDTH(WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (n_ff),
      .divisor  (d_in),
      .stat     (div_stat),
      .quotient (quotient),
      .remainder(remainder)
   );

   // semiprimes start at 4, primes at 2
   assign low_limit = (phase_ff == cpt_pkg::PH_PART_SEMI) ? WIDTH'(4) : WIDTH'(2);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      div_ctl.go   = 1'b0;
      unique case (state_ff)
         cpt_pkg::ST_IDLE: begin
            if (start) begin
               if (req_candidate[WIDTH-1]) begin
                  // negative values are never prime
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = cpt_pkg::CLASS_NOT_PRIME;
               end else begin
                  n_in     = req_candidate;
                  phase_in = cpt_pkg::PH_CAND_PRIME;
                  state_in = cpt_pkg::ST_CHECK;
               end
            end
         end
         cpt_pkg::ST_CHECK: begin
            // small values settle without any division
            if (n_ff < low_limit) begin
               verdict_in = 1'b0;
               state_in   = cpt_pkg::ST_VERDICT;
            end else begin
               d_in       = WIDTH'(2);
               div_ctl.go = 1'b1;
               state_in   = cpt_pkg::ST_DIV;
            end
         end
         cpt_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = cpt_pkg::ST_EVAL;
            end
         end
         cpt_pkg::ST_EVAL: begin
            if (d_ff > quotient) begin
               // past the square root with no factor found
               verdict_in = (phase_ff != cpt_pkg::PH_PART_SEMI);
               state_in   = cpt_pkg::ST_VERDICT;
            end else if (remainder == '0) begin
               if (phase_ff == cpt_pkg::PH_PART_SEMI) begin
                  // smallest factor found, partner is semiprime iff cofactor is prime
                  n_in     = quotient;
                  phase_in = cpt_pkg::PH_COFACTOR_PRIME;
                  state_in = cpt_pkg::ST_CHECK;
               end else begin
                  verdict_in = 1'b0;
                  state_in   = cpt_pkg::ST_VERDICT;
               end
            end else begin
               // after 2 only odd divisors need trying
               d_in       = (d_ff == WIDTH'(2)) ? WIDTH'(3) : d_ff + WIDTH'(2);
               div_ctl.go = 1'b1;
               state_in   = cpt_pkg::ST_DIV;
            end
         end
         cpt_pkg::ST_VERDICT: begin
            state_in = cpt_pkg::ST_IDLE;
            unique case (phase_ff)
               cpt_pkg::PH_CAND_PRIME: begin
                  if (verdict_ff) begin
                     // candidate is prime, move on to the partner p+2
                     n_in     = n_ff + WIDTH'(2);
                     phase_in = cpt_pkg::PH_PART_PRIME;
                     state_in = cpt_pkg::ST_CHECK;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = cpt_pkg::CLASS_NOT_PRIME;
                  end
               end
               cpt_pkg::PH_PART_PRIME: begin
                  if (verdict_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = cpt_pkg::CLASS_CHEN_PRIME;
                  end else begin
                     phase_in = cpt_pkg::PH_PART_SEMI;
                     state_in = cpt_pkg::ST_CHECK;
                  end
               end
               cpt_pkg::PH_PART_SEMI: begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = cpt_pkg::CLASS_PRIME;
               end
               cpt_pkg::PH_COFACTOR_PRIME: begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = verdict_ff ? cpt_pkg::CLASS_CHEN_SEMI : cpt_pkg::CLASS_PRIME;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = cpt_pkg::CLASS_NOT_PRIME;
               end
            endcase
         end
         default: begin
            state_in = cpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      n_ff        <= n_in;
      d_ff        <= d_in;
      verdict_ff  <= verdict_in;
      rsp_code_ff <= rsp_code_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // idle also means no division in flight
   assign busy           = (state_ff != cpt_pkg::ST_IDLE) || div_stat.running;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_class_code = rsp_code_ff;

endmodule
